FILE: src/pgw_pkg.sv
package pgw_pkg;

   localparam int WORD_W       = 64;
   localparam int PA_W         = 52;
   localparam int VA_W         = 48;
   localparam int WIDX_W       = 14;
   localparam int IDX_W        = 9;
   localparam int OFFSET_W     = 12;
   localparam int FRAME_LSB    = 12;
   localparam int WORD_SHIFT   = 3;
   localparam int LEVEL_W      = 2;
   localparam int LAST_LEVEL   = 3;
   localparam int PRESENT_BIT  = 0;
   // word index of a walk step: base/8 (49 bits) plus a 9-bit index, one carry bit
   localparam int WALK_IDX_W   = PA_W - WORD_SHIFT + 1;
   localparam int MEM_WORDS_DEF = 16384;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_WALK  = 1'b1
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } back_state_type;

   typedef struct packed {
      op_kind_type             op;
      logic [WIDX_W-1:0]       widx;
      logic [WORD_W-1:0]       value;
      logic [VA_W-1:0]         va;
   } queue_item_type;

   // table index for one level: 47:39, 38:30, 29:21, 20:12
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [LEVEL_W-1:0] level);
      logic [IDX_W-1:0] idx;
      case (level)
         2'd0: idx = va[47:39];
         2'd1: idx = va[38:30];
         2'd2: idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

FILE: src/pgw_ram.sv
module pgw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pgw_front.sv
module pgw_front #(
   parameter int MEM_WORDS = pgw_pkg::MEM_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [pgw_pkg::WIDX_W-1:0]      req_entry_word_index,
   input  logic [pgw_pkg::WORD_W-1:0]      req_entry_value,
   input  logic [pgw_pkg::VA_W-1:0]        req_virt_addr,
   input  logic                            clear_busy,
   output logic                            q_valid,
   output pgw_pkg::queue_item_type         q_item,
   input  logic                            q_pop
);

   import pgw_pkg::*;

   queue_item_type     item_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               accept;
   logic               push;
   logic               write_in_range;
   queue_item_type     new_item;

   assign req_stall = clear_busy || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // drop writes that land beyond the store
   assign write_in_range = 32'(req_entry_word_index) < 32'(MEM_WORDS);

   always_comb begin
      new_item.op    = req_func ? OP_WALK : OP_WRITE;
      new_item.widx  = req_entry_word_index;
      new_item.value = req_entry_value;
      new_item.va    = req_virt_addr;
      push = accept && ((new_item.op == OP_WALK) || write_in_range);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = item_ff[rd_ptr_ff];

endmodule

FILE: src/pgw_back.sv
module pgw_back #(
   parameter int MEM_WORDS = pgw_pkg::MEM_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pgw_pkg::PA_W-1:0]        root_base,
   input  logic                            q_valid,
   input  pgw_pkg::queue_item_type         q_item,
   output logic                            q_pop,
   output logic                            clear_busy,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pgw_pkg::PA_W-1:0]        rsp_phys_addr,
   output logic                            rsp_fault
);

   import pgw_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int XW = (AW > WIDX_W) ? AW : WIDX_W;

   back_state_type      st_ff, st_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [LEVEL_W-1:0]  level_next;
   logic [VA_W-1:0]     va_ff, va_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]     rsp_phys_ff, rsp_phys_in;
   logic                rsp_fault_ff, rsp_fault_in;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_addr;
   logic [WORD_W-1:0]   ram_wdata, ram_rdata;

   logic                out_free;
   logic [XW-1:0]       waddr_wide;
   logic [WALK_IDX_W-1:0] root_idx, next_idx;

   pgw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign waddr_wide = XW'(q_item.widx);
   assign level_next = level_ff + 1'b1;
   assign root_idx   = WALK_IDX_W'(root_base[PA_W-1:WORD_SHIFT])
                       + WALK_IDX_W'(level_index(q_item.va, '0));
   // frame<<12 >> 3 has nine zero low bits, so the index just fills them
   assign next_idx   = {1'b0, ram_rdata[PA_W-1:FRAME_LSB], level_index(va_ff, level_next)};

   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_phys_in  = rsp_phys_ff;
      rsp_fault_in = rsp_fault_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = clr_ff;
      ram_wdata    = '0;
      q_pop        = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               st_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_WRITE) begin
                  ram_we    = 1'b1;
                  ram_addr  = waddr_wide[AW-1:0];
                  ram_wdata = q_item.value;
                  q_pop     = 1'b1;
               end else if (root_idx >= WALK_IDX_W'(MEM_WORDS)) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_phys_in  = '0;
                     rsp_fault_in = 1'b1;
                  end
               end else begin
                  q_pop    = 1'b1;
                  ram_re   = 1'b1;
                  ram_addr = root_idx[AW-1:0];
                  va_in    = q_item.va;
                  level_in = '0;
                  st_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // hold in place while the result register is blocked; read data stays
            if (!ram_rdata[PRESENT_BIT] || ((level_ff != LEVEL_W'(LAST_LEVEL))
                && (next_idx >= WALK_IDX_W'(MEM_WORDS)))) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_phys_in  = '0;
                  rsp_fault_in = 1'b1;
                  st_in        = ST_IDLE;
               end
            end else if (level_ff == LEVEL_W'(LAST_LEVEL)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_phys_in  = {ram_rdata[PA_W-1:FRAME_LSB], va_ff[OFFSET_W-1:0]};
                  rsp_fault_in = 1'b0;
                  st_in        = ST_IDLE;
               end
            end else begin
               ram_re   = 1'b1;
               ram_addr = next_idx[AW-1:0];
               level_in = level_next;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff        <= va_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign clear_busy    = (st_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_phys_ff;
   assign rsp_fault     = rsp_fault_ff;

endmodule

FILE: src/four_level_page_walk_top.sv
// Port group  Direction  Contents
// req_*       in         func, entry_word_index, entry_value, virt_addr; valid/stall
// rsp_*       out        phys_addr, fault; valid/stall
// csr_*       in         root_table_base write (enable, data)
//
// A table write is a single RAM write in the walk engine; a full translation is
// the root index add and four dependent reads of the single-port table RAM,
// then a load of the result register; a fault ends the walk early.
// After reset the table RAM is swept to zero with req_stall high.
// A two-entry request queue lets requests land while a walk runs or a result waits.
module four_level_page_walk_top #(
   parameter int MEM_WORDS = pgw_pkg::MEM_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [pgw_pkg::WIDX_W-1:0]      req_entry_word_index,
   input  logic [pgw_pkg::WORD_W-1:0]      req_entry_value,
   input  logic [pgw_pkg::VA_W-1:0]        req_virt_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pgw_pkg::PA_W-1:0]        rsp_phys_addr,
   output logic                            rsp_fault,
   input  logic                            csr_write_enable,
   input  logic [pgw_pkg::PA_W-1:0]        csr_write_data
);

   import pgw_pkg::*;

   logic [PA_W-1:0]  root_ff, root_in;
   logic             clear_busy;
   logic             q_valid;
   logic             q_pop;
   queue_item_type   q_item;

   assign root_in = csr_write_enable ? csr_write_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   pgw_front #(
      .MEM_WORDS (MEM_WORDS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_entry_word_index (req_entry_word_index),
      .req_entry_value      (req_entry_value),
      .req_virt_addr        (req_virt_addr),
      .clear_busy           (clear_busy),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop)
   );

   pgw_back #(
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .root_base     (root_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .clear_busy    (clear_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_phys_addr (rsp_phys_addr),
      .rsp_fault     (rsp_fault)
   );

endmodule

FILE: sim/four_level_page_walk_top_test.sv
module four_level_page_walk_top_test;
   import pgw_pkg::*;

   localparam int STORE_WORDS    = MEM_WORDS_DEF;
   localparam int STORE_PAGES    = STORE_WORDS / 512;
   localparam int HALF_PERIOD    = 4;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int BLOCK_ITEMS    = 56;

   typedef struct packed {
      logic [PA_W-1:0] phys;
      logic            fault;
   } walk_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = 1'b0;
   logic [WIDX_W-1:0]   req_entry_word_index = '0;
   logic [WORD_W-1:0]   req_entry_value = '0;
   logic [VA_W-1:0]     req_virt_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PA_W-1:0]     rsp_phys_addr;
   logic                rsp_fault;
   logic                csr_write_enable = 1'b0;
   logic [PA_W-1:0]     csr_write_data = '0;

   // predictor state: table words and the root register
   logic [WORD_W-1:0]   page_words [STORE_WORDS] = '{default: '0};
   logic [PA_W-1:0]     root_base = '0;

   queue_item_type      pending_reqs [$];
   queue_item_type      req_on_bus;
   walk_result_type     expected_walks [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int pushed_count = 0;
   int accepted_count = 0;
   int walk_count = 0;
   int fault_count = 0;
   int root_settings = 0;
   int mismatch_count = 0;

   four_level_page_walk_top #(
      .MEM_WORDS(STORE_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_entry_word_index(req_entry_word_index),
      .req_entry_value(req_entry_value),
      .req_virt_addr(req_virt_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_fault(rsp_fault),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VA_W-1:0] rand_va();
      return VA_W'({$urandom, $urandom});
   endfunction

   function automatic walk_result_type predict_walk(input logic [VA_W-1:0] va);
      walk_result_type  r;
      logic [PA_W-1:0]  base;
      logic [63:0]      word_idx;
      logic [WORD_W-1:0] entry;
      r.phys = '0;
      r.fault = 1'b0;
      base = root_base;
      for (int lvl = 0; lvl < 4; lvl++) begin
         if (!r.fault) begin
            word_idx = ({12'b0, base} >> WORD_SHIFT) + ((va >> (39 - 9 * lvl)) & 48'h1FF);
            if (word_idx >= STORE_WORDS) begin
               r.fault = 1'b1;
            end else begin
               entry = page_words[word_idx[WIDX_W-1:0]];
               if (!entry[PRESENT_BIT])
                  r.fault = 1'b1;
               else
                  base = {entry[PA_W-1:FRAME_LSB], 12'b0};
            end
         end
      end
      if (!r.fault)
         r.phys = base + PA_W'(va[OFFSET_W-1:0]);
      return r;
   endfunction

   function automatic void record_request(input queue_item_type it);
      walk_result_type r;
      if (it.op == OP_WRITE) begin
         page_words[it.widx] = it.value;
      end else begin
         r = predict_walk(it.va);
         expected_walks.push_back(r);
         walk_count++;
         if (r.fault)
            fault_count++;
      end
   endfunction

   task automatic push_write(input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] value);
      queue_item_type it;
      it.op = OP_WRITE;
      it.widx = widx;
      it.value = value;
      it.va = rand_va();
      pending_reqs.push_back(it);
      pushed_count++;
   endtask

   task automatic push_walk(input logic [VA_W-1:0] va);
      queue_item_type it;
      it.op = OP_WALK;
      it.widx = WIDX_W'($urandom);
      it.value = rand64();
      it.va = va;
      pending_reqs.push_back(it);
      pushed_count++;
   endtask

   // Write a table chain for a random address, then translate it and neighbors.
   // Now and then break the chain: a cleared present bit or a missing entry.
   task automatic push_chain(input logic [PA_W-1:0] root);
      logic [VA_W-1:0]   va;
      logic [PA_W-1:0]   base;
      logic [63:0]       widx;
      logic [WORD_W-1:0] entry;
      int                broken_lvl;
      bit                open;
      va = rand_va();
      base = root;
      open = 1'b1;
      broken_lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
      for (int lvl = 0; lvl < 4; lvl++) begin
         if (open) begin
            widx = ({12'b0, base} >> WORD_SHIFT) + ((va >> (39 - 9 * lvl)) & 48'h1FF);
            entry = rand64();
            entry[PRESENT_BIT] = 1'b1;
            if (lvl < 3 && $urandom_range(0, 15) != 0)
               entry[PA_W-1:FRAME_LSB] = 40'($urandom_range(0, STORE_PAGES - 1));
            if (widx >= STORE_WORDS) begin
               open = 1'b0;
            end else if (lvl == broken_lvl) begin
               if ($urandom_range(0, 1)) begin
                  entry[PRESENT_BIT] = 1'b0;
                  push_write(widx[WIDX_W-1:0], entry);
               end
               open = 1'b0;
            end else begin
               push_write(widx[WIDX_W-1:0], entry);
               base = {entry[PA_W-1:FRAME_LSB], 12'b0};
            end
         end
      end
      push_walk(va);
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1))
            push_walk({va[VA_W-1:12], 12'($urandom)});
         else
            push_walk({va[VA_W-1:21], 21'($urandom)});
      end
   endtask

   function automatic logic [PA_W-1:0] pick_root();
      logic [PA_W-1:0] r;
      case ($urandom_range(0, 7))
         0:       r = PA_W'({$urandom, $urandom});
         1, 2:    r = (PA_W'($urandom_range(0, STORE_PAGES - 1)) << 12)
                      | PA_W'($urandom_range(0, 4095));
         default: r = PA_W'($urandom_range(0, STORE_PAGES - 1)) << 12;
      endcase
      return r;
   endfunction

   // Hold until every request is in and answered, then let writes drain.
   task automatic settle_idle();
      while (accepted_count != pushed_count || expected_walks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_root(input logic [PA_W-1:0] value);
      settle_idle();
      root_base = value;
      root_settings++;
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            record_request(req_on_bus);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_on_bus = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= req_on_bus.op;
               req_entry_word_index <= req_on_bus.widx;
               req_entry_value <= req_on_bus.value;
               req_virt_addr <= req_on_bus.va;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_walks.size() == 0) begin
               $error("unexpected response: phys_addr %h fault %b", rsp_phys_addr, rsp_fault);
               mismatch_count++;
            end else begin
               want = expected_walks.pop_front();
               if (rsp_phys_addr !== want.phys) begin
                  $error("phys_addr: expected %h, got %h", want.phys, rsp_phys_addr);
                  mismatch_count++;
               end
               if (rsp_fault !== want.fault) begin
                  $error("fault: expected %b, got %b", want.fault, rsp_fault);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int block_start;
      int wait_cycles;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      load_root('0);
      push_walk('0);
      push_write(14'd0, '1);
      push_walk('0);
      push_write(14'd511, 64'h1001);
      push_write(14'd1023, 64'h2001);
      push_write(14'd1535, 64'h3001);
      push_write(14'd2047, 64'hFFFF_FFFF_FFFF_F001);
      push_walk('1);
      // every flag set but present
      push_write(14'd2047, 64'hFFFF_FFFF_FFFF_FFFE);
      push_walk('1);
      push_write(14'd2047, 64'h1);
      push_walk('1);
      push_write(14'd16383, '1);
      push_write(14'd16383, '0);

      load_root('1);
      push_walk('0);
      push_walk('1);

      // unaligned root: bits 11:3 shift the top table by 511 words
      load_root(52'hFF8);
      push_write(14'd512, 64'h2001);
      push_write(14'd1024, 64'h3001);
      push_write(14'd1536, 64'hABCD_E001);
      push_walk(48'h123);

      for (int p = 0; p < 3; p++) begin
         for (int b = 0; b < 3; b++) begin
            load_root(pick_root());
            send_idle_pct = (p == 0) ? 32 : (p == 1) ? 51 : 0;
            recv_stall_pct = (p == 0) ? 51 : (p == 1) ? 32 : 0;
            block_start = pushed_count;
            while (pushed_count - block_start < BLOCK_ITEMS) begin
               case ($urandom_range(0, 5))
                  0:       push_write(WIDX_W'($urandom), rand64());
                  1:       push_walk(rand_va());
                  default: push_chain(root_base);
               endcase
            end
         end
      end

      while (accepted_count != pushed_count)
         @(posedge clock);
      wait_cycles = 0;
      while (expected_walks.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_walks.size() != 0) begin
         $error("%0d translations never answered", expected_walks.size());
         mismatch_count++;
      end
      $display("Sent %0d requests: %0d translations, %0d of them faults, over %0d root settings",
               accepted_count, walk_count, fault_count, root_settings);
      $display("Idle mixes: sender-heavy, receiver-heavy and back-to-back");
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
src/pgw_pkg.sv
src/pgw_ram.sv
src/pgw_front.sv
src/pgw_back.sv
src/four_level_page_walk_top.sv
sim/four_level_page_walk_top_test.sv
